// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the frame receiver. Each macro
// samples on clk_i and is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define FPR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("framed receiver check failed");

// The expression must never be true at a clock edge out of reset.
`define FPR_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("framed receiver forbidden condition seen");

`endif

// File: rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// Framed packet receiver package
// Phase and sequencer encodings, result status codes, register indexes and
// the fixed constants of the stuffed frame format.
// ----------------------------------------------------------------------------
package fpr_pkg;

  // Frame parsing phase, advanced one received word at a time.
  typedef enum logic [2:0] {
    PhWait,
    PhOvh,
    PhId,
    PhLen,
    PhPay,
    PhCrc,
    PhStop
  } phase_e;

  // Sequencer that runs the chain walk, the CRC pass and the payload run.
  typedef enum logic [3:0] {
    SeqIdle,
    SeqWalkChk,
    SeqWalkUpd,
    SeqCrcId,
    SeqCrcLen,
    SeqCrcRd,
    SeqCrcAcc,
    SeqCrcCmp,
    SeqPost,
    SeqEmitRd,
    SeqEmitOut
  } seq_e;

  // Result status codes.
  localparam logic [2:0] StBusy    = 3'd0;
  localparam logic [2:0] StPayload = 3'd1;
  localparam logic [2:0] StBadLen  = 3'd2;
  localparam logic [2:0] StCrcBad  = 3'd3;
  localparam logic [2:0] StNoStop  = 3'd4;
  localparam logic [2:0] StOverrun = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CfgStart   = 2'd0;
  localparam logic [1:0] CfgStop    = 2'd1;
  localparam logic [1:0] CfgTimeout = 2'd2;

  // Register reset values.
  localparam logic [7:0]  StartReset   = 8'd126;
  localparam logic [7:0]  StopReset    = 8'd129;
  localparam logic [15:0] TimeoutReset = 16'd50;

  // Frame format constants.
  localparam logic [7:0]  NoStuff  = 8'd254;
  localparam logic [7:0]  CrcPoly  = 8'h9B;
  localparam logic [15:0] AgeMax   = 16'hFFFF;

endpackage

// File: rtl/framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// Framed packet receiver
// Takes one received word per input (or a time tick when cmd_i is 1) and
// reports busy, error or a run of restored payload bytes on the output.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i/in_ready_o) carries cmd_i and rx_byte_i.
// Every input word yields at least one result on the output channel
// (out_valid_o/out_ready_i); last_o marks the final result of that word.
// Ordinary words and ticks are handled at once: the result sits in the output
// register on the following cycle and the next word is taken once it is free.
// The CRC word starts the frame check: per stuffed chain link a bounds check
// and read, then a restore; then the id and length steps; per payload byte a
// read and an accumulate step; the read of the CRC word, the compare and the
// posting of the outcome, all through one shared CRC unit and the single read
// port of the frame memory; in_ready_o stays low meanwhile. A good stop word
// starts the payload run, a memory read and then an output load for each byte.
// When the receiver stalls, the pending result holds and no new word is taken.
// Reset returns to waiting for a start word and loads the register defaults;
// the frame memory needs no clearing. Configuration writes (cfg_valid_i,
// cfg_index_i, cfg_data_i) are always ready and are meant for idle periods.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module framed_packet_receiver #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [1:0]                         cfg_index_i,
  input  logic [15:0]                        cfg_data_i,
  // input words
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               cmd_i,
  input  logic [7:0]                         rx_byte_i,
  // results
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [2:0]                         status_o,
  output logic                               timed_out_o,
  output logic [7:0]                         frame_id_o,
  output logic [$clog2(MAX_PAYLOAD+1)-1:0]   frame_len_o,
  output logic [7:0]                         payload_byte_o,
  output logic                               last_o
);

  localparam int LenW  = $clog2(MAX_PAYLOAD + 1);
  localparam int IdxW  = $clog2(MAX_PAYLOAD + 256);
  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  // Configuration registers.
  logic [7:0]  start_q;
  logic [7:0]  stop_q;
  logic [15:0] timeout_q;

  // Frame state.
  fpr_pkg::phase_e phase_q, phase_d;
  fpr_pkg::seq_e   seq_q, seq_d;
  logic [15:0]     age_q, age_d;
  logic [7:0]      ovh_q, ovh_d;
  logic [7:0]      id_q, id_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] fill_q, fill_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      crc_q, crc_d;
  logic            timed_q, timed_d;
  logic [2:0]      res_q, res_d;

  // Output register.
  logic            out_valid_q;
  logic            out_load;
  logic            out_free;
  logic [2:0]      o_status, status_q;
  logic            o_timed, timed_out_q;
  logic [7:0]      o_id, frame_id_q;
  logic [LenW-1:0] o_len, frame_len_q;
  logic [7:0]      o_pay, payload_q;
  logic            o_last, last_q;

  // Frame memory ports.
  logic            ram_we;
  logic [LenW-1:0] ram_waddr;
  logic [7:0]      ram_wdata;
  logic            ram_re;
  logic [LenW-1:0] ram_raddr;
  logic [7:0]      ram_rdata;

  // Shared CRC unit.
  logic [7:0]      crc_in;
  logic [7:0]      crc_byte;
  logic [7:0]      crc_out;

  // Aging of the current frame.
  logic            in_frame;
  logic [15:0]     age_tick;
  logic            tmo;
  fpr_pkg::phase_e phase_eff;
  logic            len_ok;
  logic            emit_last;

  fpr_ram #(
    .Width (8),
    .Depth (MAX_PAYLOAD + 1)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fpr_crc8 u_crc (
    .crc_i  (crc_in),
    .byte_i (crc_byte),
    .crc_o  (crc_out)
  );

  // Configuration writes; indexes past the list are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= fpr_pkg::StartReset;
      stop_q    <= fpr_pkg::StopReset;
      timeout_q <= fpr_pkg::TimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        fpr_pkg::CfgStart:   start_q   <= cfg_data_i[7:0];
        fpr_pkg::CfgStop:    stop_q    <= cfg_data_i[7:0];
        fpr_pkg::CfgTimeout: timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A tick ages the open frame; a stale frame is dropped before the word.
  assign in_frame  = (phase_q != fpr_pkg::PhWait);
  assign age_tick  = (cmd_i && in_frame && (age_q != fpr_pkg::AgeMax)) ? age_q + 16'd1 : age_q;
  assign tmo       = in_frame && (age_tick >= timeout_q);
  assign phase_eff = tmo ? fpr_pkg::PhWait : phase_q;
  assign len_ok    = (rx_byte_i != 8'd0) && (rx_byte_i <= MaxLen);
  assign emit_last = (LenW'(cnt_q + 1'b1) == len_q);

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (seq_q == fpr_pkg::SeqIdle) && out_free;

  // Sequencer: word parsing, chain walk, CRC pass and payload run.
  always_comb begin
    phase_d   = phase_q;
    seq_d     = seq_q;
    age_d     = age_q;
    ovh_d     = ovh_q;
    id_d      = id_q;
    len_d     = len_q;
    fill_d    = fill_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    crc_d     = crc_q;
    timed_d   = timed_q;
    res_d     = res_q;
    out_load  = 1'b0;
    o_status  = fpr_pkg::StBusy;
    o_timed   = timed_q;
    o_id      = '0;
    o_len     = '0;
    o_pay     = '0;
    o_last    = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    crc_in    = crc_q;
    crc_byte  = ram_rdata;

    unique case (seq_q)
      fpr_pkg::SeqIdle: begin
        if (in_valid_i && in_ready_o) begin
          timed_d  = tmo;
          o_timed  = tmo;
          out_load = 1'b1;
          if (cmd_i) begin
            if (tmo) begin
              phase_d = fpr_pkg::PhWait;
              age_d   = '0;
            end else begin
              age_d = age_tick;
            end
          end else if (rx_byte_i == start_q) begin
            // A start word always opens a fresh frame.
            phase_d = fpr_pkg::PhOvh;
            age_d   = '0;
          end else begin
            if (tmo) begin
              phase_d = fpr_pkg::PhWait;
              age_d   = '0;
            end
            unique case (phase_eff)
              fpr_pkg::PhWait: ;
              fpr_pkg::PhOvh: begin
                ovh_d   = rx_byte_i;
                phase_d = fpr_pkg::PhId;
              end
              fpr_pkg::PhId: begin
                id_d    = rx_byte_i;
                phase_d = fpr_pkg::PhLen;
              end
              fpr_pkg::PhLen: begin
                if (len_ok) begin
                  len_d   = LenW'(rx_byte_i);
                  fill_d  = '0;
                  phase_d = fpr_pkg::PhPay;
                end else begin
                  phase_d  = fpr_pkg::PhWait;
                  age_d    = '0;
                  o_status = fpr_pkg::StBadLen;
                  o_id     = id_q;
                end
              end
              fpr_pkg::PhPay: begin
                ram_we    = 1'b1;
                ram_waddr = fill_q;
                ram_wdata = rx_byte_i;
                fill_d    = LenW'(fill_q + 1'b1);
                if (LenW'(fill_q + 1'b1) >= len_q) begin
                  phase_d = fpr_pkg::PhCrc;
                end
              end
              fpr_pkg::PhCrc: begin
                // Store the CRC word and start the frame check.
                ram_we    = 1'b1;
                ram_waddr = len_q;
                ram_wdata = rx_byte_i;
                out_load  = 1'b0;
                idx_d     = IdxW'(ovh_q);
                if (ovh_q == fpr_pkg::NoStuff) begin
                  seq_d = fpr_pkg::SeqCrcId;
                end else begin
                  seq_d = fpr_pkg::SeqWalkChk;
                end
              end
              fpr_pkg::PhStop: begin
                phase_d = fpr_pkg::PhWait;
                age_d   = '0;
                if (rx_byte_i == stop_q) begin
                  out_load = 1'b0;
                  cnt_d    = '0;
                  seq_d    = fpr_pkg::SeqEmitRd;
                end else begin
                  o_status = fpr_pkg::StNoStop;
                  o_id     = id_q;
                  o_len    = len_q;
                end
              end
              default: begin
                phase_d = fpr_pkg::PhWait;
                age_d   = '0;
              end
            endcase
          end
        end
      end

      // Chain walk: bounds check and read of the next stuffed position.
      fpr_pkg::SeqWalkChk: begin
        if (idx_q > IdxW'(len_q)) begin
          phase_d = fpr_pkg::PhWait;
          age_d   = '0;
          res_d   = fpr_pkg::StOverrun;
          seq_d   = fpr_pkg::SeqPost;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[LenW-1:0];
          seq_d     = fpr_pkg::SeqWalkUpd;
        end
      end

      // Restore the start word there and follow the stored distance.
      fpr_pkg::SeqWalkUpd: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[LenW-1:0];
        ram_wdata = start_q;
        if (ram_rdata == 8'd0) begin
          seq_d = fpr_pkg::SeqCrcId;
        end else begin
          idx_d = idx_q + IdxW'(ram_rdata);
          seq_d = fpr_pkg::SeqWalkChk;
        end
      end

      fpr_pkg::SeqCrcId: begin
        crc_in   = '0;
        crc_byte = id_q;
        crc_d    = crc_out;
        seq_d    = fpr_pkg::SeqCrcLen;
      end

      fpr_pkg::SeqCrcLen: begin
        crc_byte = 8'(len_q);
        crc_d    = crc_out;
        cnt_d    = '0;
        seq_d    = fpr_pkg::SeqCrcRd;
      end

      // Read payload bytes in order, then the CRC word itself.
      fpr_pkg::SeqCrcRd: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_q;
        if (cnt_q == len_q) begin
          seq_d = fpr_pkg::SeqCrcCmp;
        end else begin
          seq_d = fpr_pkg::SeqCrcAcc;
        end
      end

      fpr_pkg::SeqCrcAcc: begin
        crc_d = crc_out;
        cnt_d = LenW'(cnt_q + 1'b1);
        seq_d = fpr_pkg::SeqCrcRd;
      end

      fpr_pkg::SeqCrcCmp: begin
        if (ram_rdata != crc_q) begin
          phase_d = fpr_pkg::PhWait;
          age_d   = '0;
          res_d   = fpr_pkg::StCrcBad;
        end else begin
          phase_d = fpr_pkg::PhStop;
          res_d   = fpr_pkg::StBusy;
        end
        seq_d = fpr_pkg::SeqPost;
      end

      // Hand the outcome of the frame check to the output register.
      fpr_pkg::SeqPost: begin
        if (out_free) begin
          out_load = 1'b1;
          o_status = res_q;
          if (res_q != fpr_pkg::StBusy) begin
            o_id  = id_q;
            o_len = len_q;
          end
          seq_d = fpr_pkg::SeqIdle;
        end
      end

      fpr_pkg::SeqEmitRd: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_q;
        seq_d     = fpr_pkg::SeqEmitOut;
      end

      fpr_pkg::SeqEmitOut: begin
        if (out_free) begin
          out_load = 1'b1;
          o_status = fpr_pkg::StPayload;
          o_id     = id_q;
          o_len    = len_q;
          o_pay    = ram_rdata;
          o_last   = emit_last;
          cnt_d    = LenW'(cnt_q + 1'b1);
          seq_d    = emit_last ? fpr_pkg::SeqIdle : fpr_pkg::SeqEmitRd;
        end
      end

      default: seq_d = fpr_pkg::SeqIdle;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= fpr_pkg::PhWait;
      seq_q       <= fpr_pkg::SeqIdle;
      age_q       <= '0;
      ovh_q       <= '0;
      id_q        <= '0;
      len_q       <= '0;
      fill_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      seq_q       <= seq_d;
      age_q       <= age_d;
      ovh_q       <= ovh_d;
      id_q        <= id_d;
      len_q       <= len_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_load | (out_valid_q & ~out_ready_i);
    end
  end

  // Working values and the output payload.
  always_ff @(posedge clk_i) begin
    crc_q   <= crc_d;
    timed_q <= timed_d;
    res_q   <= res_d;
    if (out_load) begin
      status_q    <= o_status;
      timed_out_q <= o_timed;
      frame_id_q  <= o_id;
      frame_len_q <= o_len;
      payload_q   <= o_pay;
      last_q      <= o_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign timed_out_o    = timed_out_q;
  assign frame_id_o     = frame_id_q;
  assign frame_len_o    = frame_len_q;
  assign payload_byte_o = payload_q;
  assign last_o         = last_q;

  // Checks on the sequencer and the frame bookkeeping.
  `FPR_ASSERT(a_ready_only_idle, in_ready_o |-> seq_q == fpr_pkg::SeqIdle)
  `FPR_ASSERT(a_walk_in_range, seq_q == fpr_pkg::SeqWalkUpd |-> idx_q <= IdxW'(len_q))
  `FPR_ASSERT(a_fill_below_len, phase_q == fpr_pkg::PhPay |-> fill_q < len_q)
  `FPR_ASSERT_NEVER(a_payload_no_len, out_valid_o && status_o == fpr_pkg::StPayload && frame_len_o == '0)

endmodule

// File: rtl/fpr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read; the read data
// holds while the read enable is low.
// ----------------------------------------------------------------------------
module fpr_ram #(
  parameter int Width = 8,
  parameter int Depth = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fpr_crc8.sv
// ----------------------------------------------------------------------------
// CRC-8 byte unit
// Folds one byte into a running CRC-8, MSB first, with the frame polynomial.
// The sequencer reuses this one unit for every byte of the check.
// ----------------------------------------------------------------------------
module fpr_crc8 (
  input  logic [7:0] crc_i,
  input  logic [7:0] byte_i,
  output logic [7:0] crc_o
);

  logic [7:0] acc;

  // Eight shift steps over the byte, one per bit.
  always_comb begin
    acc = crc_i ^ byte_i;
    for (int i = 0; i < 8; i++) begin
      if (acc[7]) begin
        acc = (acc << 1) ^ fpr_pkg::CrcPoly;
      end else begin
        acc = acc << 1;
      end
    end
  end

  assign crc_o = acc;

endmodule

// File: test/tb_framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// Framed packet receiver testbench
// Sends stuffed frames, byte words and time ticks into the receiver. A
// scoreboard class runs its own model of the frame parser, the chain restore
// and the CRC-8 check, and compares every result word field by field. Both
// channels idle at random. One long receiver hold-off fills the block. Every
// register is written with several settings, including the extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_framed_packet_receiver;

  localparam int MaxPayload    = 64;
  localparam int LenW          = $clog2(MaxPayload + 1);
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 4000;
  localparam int TailCycles    = 400;

  // One result word as the receiver reports it.
  typedef struct packed {
    logic [2:0]      status;
    logic            timed_out;
    logic [7:0]      frame_id;
    logic [LenW-1:0] frame_len;
    logic [7:0]      payload;
    logic            last;
  } frame_result_t;

  // Shapes of generated frames.
  typedef enum int {
    FrGood,
    FrBadCrc,
    FrOverrun,
    FrNoStop,
    FrBadLen,
    FrTruncated
  } frame_kind_e;

  // Scoreboard: models the receiver and holds the results still to come.
  class frame_scoreboard;
    logic [7:0]      start_b;
    logic [7:0]      stop_b;
    logic [15:0]     tmo;
    fpr_pkg::phase_e ph;
    logic            in_frame;
    logic [15:0]     age;
    logic [7:0]      ovh;
    logic [7:0]      id_r;
    logic [LenW-1:0] len_r;
    logic [LenW-1:0] fill;
    logic [7:0]      store [MaxPayload+1];
    frame_result_t   pending_results [$];
    int              errors;

    function new();
      start_b  = fpr_pkg::StartReset;
      stop_b   = fpr_pkg::StopReset;
      tmo      = fpr_pkg::TimeoutReset;
      ph       = fpr_pkg::PhWait;
      in_frame = 1'b0;
      age      = '0;
      ovh      = '0;
      id_r     = '0;
      len_r    = '0;
      fill     = '0;
      errors   = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    static function logic [7:0] crc8(logic [7:0] crc, logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
        c = c[7] ? ((c << 1) ^ fpr_pkg::CrcPoly) : (c << 1);
      end
      return c;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        fpr_pkg::CfgStart:   start_b = val[7:0];
        fpr_pkg::CfgStop:    stop_b  = val[7:0];
        fpr_pkg::CfgTimeout: tmo     = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void abandon();
      ph       = fpr_pkg::PhWait;
      in_frame = 1'b0;
      age      = '0;
    endfunction

    function void push(logic [2:0] st, logic to, logic [7:0] id, logic [LenW-1:0] ln,
                       logic [7:0] pb, logic lst);
      frame_result_t r;
      r.status    = st;
      r.timed_out = to;
      r.frame_id  = id;
      r.frame_len = ln;
      r.payload   = pb;
      r.last      = lst;
      pending_results.push_back(r);
    endfunction

    // Walk the stuffing chain and put the start byte back at each link.
    function bit restore_chain();
      int         idx;
      logic [7:0] d;
      idx = ovh;
      if (ovh == fpr_pkg::NoStuff) return 1'b1;
      while (1) begin
        if (idx > len_r) return 1'b0;
        d = store[idx];
        store[idx] = start_b;
        if (d == 8'd0) return 1'b1;
        idx += d;
      end
    endfunction

    // Work out the results of one accepted input word.
    function void note_word(logic c, logic [7:0] b);
      logic       timed;
      logic [7:0] crc;
      timed = 1'b0;
      if (c && in_frame && age < fpr_pkg::AgeMax) age++;
      if (in_frame && age >= tmo) begin
        abandon();
        timed = 1'b1;
      end
      if (c) begin
        push(fpr_pkg::StBusy, timed, '0, '0, '0, 1'b1);
        return;
      end
      // A start byte in mid-frame restarts the frame.
      if (b == start_b && ph != fpr_pkg::PhWait) abandon();
      case (ph)
        fpr_pkg::PhWait: begin
          if (b == start_b) begin
            ph       = fpr_pkg::PhOvh;
            in_frame = 1'b1;
            age      = '0;
          end
        end
        fpr_pkg::PhOvh: begin
          ovh = b;
          ph  = fpr_pkg::PhId;
        end
        fpr_pkg::PhId: begin
          id_r = b;
          ph   = fpr_pkg::PhLen;
        end
        fpr_pkg::PhLen: begin
          if (b >= 1 && b <= MaxPayload) begin
            len_r = b[LenW-1:0];
            fill  = '0;
            ph    = fpr_pkg::PhPay;
          end else begin
            abandon();
            push(fpr_pkg::StBadLen, timed, id_r, '0, '0, 1'b1);
            return;
          end
        end
        fpr_pkg::PhPay: begin
          if (fill < len_r && fill < MaxPayload) store[fill] = b;
          fill++;
          if (fill >= len_r) ph = fpr_pkg::PhCrc;
        end
        fpr_pkg::PhCrc: begin
          store[len_r] = b;
          if (!restore_chain()) begin
            abandon();
            push(fpr_pkg::StOverrun, timed, id_r, len_r, '0, 1'b1);
            return;
          end
          crc = crc8(8'd0, id_r);
          crc = crc8(crc, 8'(len_r));
          for (int i = 0; i < len_r; i++) crc = crc8(crc, store[i]);
          if (crc != store[len_r]) begin
            abandon();
            push(fpr_pkg::StCrcBad, timed, id_r, len_r, '0, 1'b1);
            return;
          end
          ph = fpr_pkg::PhStop;
        end
        fpr_pkg::PhStop: begin
          abandon();
          if (b == stop_b) begin
            for (int i = 0; i < len_r; i++) begin
              push(fpr_pkg::StPayload, timed, id_r, len_r, store[i], (i + 1 == len_r));
            end
            return;
          end
          push(fpr_pkg::StNoStop, timed, id_r, len_r, '0, 1'b1);
          return;
        end
        default: abandon();
      endcase
      push(fpr_pkg::StBusy, timed, '0, '0, '0, 1'b1);
    endfunction

    function void field_ok(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t ERROR %s expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result word with the oldest expected one.
    function void check_result(frame_result_t got);
      frame_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t ERROR unexpected result expected none actual status %0h payload %0h",
                 $time, got.status, got.payload);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      field_ok("status", want.status, got.status);
      field_ok("timed_out", want.timed_out, got.timed_out);
      field_ok("frame_id", want.frame_id, got.frame_id);
      field_ok("frame_len", want.frame_len, got.frame_len);
      field_ok("payload_byte", want.payload, got.payload);
      field_ok("last", want.last, got.last);
    endfunction
  endclass

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [1:0]      cfg_index_i = '0;
  logic [15:0]     cfg_data_i  = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  logic            cmd_i       = 1'b0;
  logic [7:0]      rx_byte_i   = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [2:0]      status_o;
  logic            timed_out_o;
  logic [7:0]      frame_id_o;
  logic [LenW-1:0] frame_len_o;
  logic [7:0]      payload_byte_o;
  logic            last_o;

  frame_scoreboard sb;
  int              words_sent = 0;
  int              idle_count = 0;
  bit              no_idle    = 1'b0;
  bit              hold_req   = 1'b0;
  bit              use_given  = 1'b0;
  logic [7:0]      given_pay [MaxPayload];
  logic [7:0]      frame_q [$];

  framed_packet_receiver #(
    .MAX_PAYLOAD(MaxPayload)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .timed_out_o   (timed_out_o),
    .frame_id_o    (frame_id_o),
    .frame_len_o   (frame_len_o),
    .payload_byte_o(payload_byte_o),
    .last_o        (last_o)
  );

  // Clock, 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver side: random stalls, plus one long hold-off on request.
  initial begin
    int r;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready_i <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk_i);
        end else if (r < 95) begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end else begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk_i);
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    frame_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status    = status_o;
      got.timed_out = timed_out_o;
      got.frame_id  = frame_id_o;
      got.frame_len = frame_len_o;
      got.payload   = payload_byte_o;
      got.last      = last_o;
      sb.check_result(got);
    end
  end

  // Watchdog: ends the run when no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_count <= 0;
      end else if (idle_count + 1 >= WatchdogLimit) begin
        $display("%0t watchdog expired", $time);
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  // Send one input word and wait until it is taken.
  task automatic send_word(input logic c, input logic [7:0] b);
    int gap;
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(c, b);
    words_sent++;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Write one configuration register.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop sending and wait until every expected result has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [7:0] st, input logic [7:0] sp, input logic [15:0] tm);
    drain();
    write_reg(fpr_pkg::CfgStart, {8'd0, st});
    write_reg(fpr_pkg::CfgStop, {8'd0, sp});
    write_reg(fpr_pkg::CfgTimeout, tm);
  endtask

  // Build the words of one frame in frame_q, stuffing every start byte value.
  task automatic build_frame(input frame_kind_e kind, input int len);
    logic [7:0] raw [MaxPayload+1];
    logic [7:0] line_b [MaxPayload+1];
    int         links [$];
    logic [7:0] crc, s, id, ovh, bad;
    int         cut;
    s  = sb.start_b;
    id = $urandom_range(0, 255);
    if (id == s) id = ~s;
    frame_q.delete();
    if (kind == FrBadLen) begin
      bad = use_given ? given_pay[0] : ($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(65, 255)));
      frame_q = '{s, 8'($urandom_range(0, 255)), id, bad};
      return;
    end
    for (int i = 0; i < len; i++) begin
      if (use_given) raw[i] = given_pay[i];
      else raw[i] = ($urandom_range(0, 3) == 0) ? s : 8'($urandom_range(0, 255));
    end
    crc = frame_scoreboard::crc8(8'd0, id);
    crc = frame_scoreboard::crc8(crc, 8'(len));
    for (int i = 0; i < len; i++) crc = frame_scoreboard::crc8(crc, raw[i]);
    if (kind == FrBadCrc) crc ^= 8'(1 << $urandom_range(0, 7));
    raw[len] = crc;
    for (int i = 0; i <= len; i++) begin
      line_b[i] = raw[i];
      if (raw[i] == s) links.push_back(i);
    end
    foreach (links[k]) begin
      line_b[links[k]] = (k == links.size() - 1) ? 8'd0 : 8'(links[k+1] - links[k]);
    end
    ovh = (links.size() > 0) ? 8'(links[0]) : fpr_pkg::NoStuff;
    if (kind == FrOverrun) begin
      if (links.size() > 0 && $urandom_range(0, 1)) begin
        line_b[links[$]] = 8'(len + 1 - links[$] + $urandom_range(0, 3));
      end else begin
        ovh = 8'($urandom_range(len + 1, 253));
      end
    end
    frame_q.push_back(s);
    frame_q.push_back(ovh);
    frame_q.push_back(id);
    frame_q.push_back(8'(len));
    for (int i = 0; i <= len; i++) frame_q.push_back(line_b[i]);
    if (kind == FrNoStop) frame_q.push_back(sb.stop_b + 8'($urandom_range(1, 255)));
    else frame_q.push_back(sb.stop_b);
    if (kind == FrTruncated) begin
      cut = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
  endtask

  // Send a frame word by word, with ticks mixed in at the given odds.
  task automatic send_frame(input frame_kind_e kind, input int len, input int tick_pct);
    build_frame(kind, len);
    foreach (frame_q[i]) begin
      if ($urandom_range(0, 99) < tick_pct) send_word(1'b1, 8'($urandom_range(0, 255)));
      send_word(1'b0, frame_q[i]);
    end
    if (kind == FrTruncated) begin
      repeat ($urandom_range(0, 3)) send_word(1'b1, 8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly well-formed frames with random content, some broken ones and noise.
  task automatic run_random(input int quota);
    int          target, r, len;
    frame_kind_e kind;
    target = words_sent + quota;
    while (words_sent < target) begin
      no_idle = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) kind = FrGood;
        else if (r < 68) kind = FrBadCrc;
        else if (r < 76) kind = FrOverrun;
        else if (r < 84) kind = FrNoStop;
        else if (r < 92) kind = FrBadLen;
        else kind = FrTruncated;
        len = ($urandom_range(0, 19) == 0) ? MaxPayload : $urandom_range(1, 6);
        send_frame(kind, len, 10);
      end
    end
    no_idle = 1'b0;
  endtask

  // Main sequence.
  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset register values.
    send_word(1'b1, 8'hFF);
    use_given    = 1'b1;
    given_pay[0] = sb.start_b;
    given_pay[1] = 8'hFF;
    send_frame(FrGood, 2, 0);
    given_pay[0] = 8'd0;
    send_frame(FrBadLen, 0, 0);
    // A start byte in mid-frame restarts the frame.
    send_word(1'b0, sb.start_b);
    send_word(1'b0, 8'h00);
    given_pay[0] = 8'hFF;
    send_frame(FrBadLen, 0, 0);
    given_pay[0] = 8'h00;
    send_frame(FrOverrun, 1, 0);
    use_given = 1'b0;

    // Largest start byte, smallest stop byte and the longest timeout.
    set_regs(8'hFF, 8'h00, 16'hFFFF);
    run_random(100);

    // Smallest start byte, largest stop byte; a single tick ends a frame.
    set_regs(8'h00, 8'hFF, 16'd1);
    run_random(60);

    // Stop byte equal to start byte, and a zero timeout.
    set_regs(8'd126, 8'd126, 16'd0);
    run_random(20);

    // Back near the defaults, with the long receiver hold-off.
    set_regs(8'($urandom_range(128, 253)), fpr_pkg::StopReset, 16'd6);
    hold_req = 1'b1;
    run_random(40);
    drain();
    run_random(80);

    // Let the last results out and look for stray ones.
    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
